// ----- rtl/core/rmcr_pkg.sv -----
// Package for the random masked choice reroller.
// Holds payload structs, register codes, sequencer states and fixed constants.
// No dependencies.
package rmcr_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned CHOICE_W     = 5;
    localparam int unsigned TYPE_W       = 16;
    localparam int unsigned WEIGHT_W     = 8;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CHOICE_COUNT = 31;

    // Remainder unit: divisor is at most 100, so remainders fit in seven bits.
    localparam int unsigned DIV_W       = 7;
    localparam int unsigned MOD_BITS    = 2;
    localparam int unsigned MOD_STEPS   = WORD_W / MOD_BITS;
    localparam int unsigned STEP_W      = $clog2(MOD_STEPS);

    // Choice scan: a few mask bits per cycle.
    localparam int unsigned SCAN_LANES  = 4;
    localparam int unsigned LANE_W      = $clog2(SCAN_LANES);
    localparam int unsigned SCAN_STEPS  = WORD_W / SCAN_LANES;
    localparam int unsigned SCAN_IDX_W  = $clog2(SCAN_STEPS);

    localparam logic [WORD_W-1:0] MIX_MUL_A    = 32'h7FEB352D;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 32'h846CA68B;
    localparam logic [WORD_W-1:0] GOLDEN       = 32'h9E3779B9;
    localparam logic [WORD_W-1:0] SEED_SALT    = 32'hA5C39E21;
    localparam logic [WORD_W-1:0] NONZERO_FILL = 32'h6D2B79F5;
    localparam logic [WORD_W-1:0] TABLE_BASE   = 32'h0035164E;
    localparam logic [WORD_W-1:0] WINDOW_LOW   = 32'h02000000;
    localparam logic [WORD_W-1:0] WINDOW_HIGH  = 32'h02040000;

    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 8'd100;
    localparam logic [DIV_W-1:0]    PERCENT_DIV = 7'd100;
    localparam int unsigned         PASS_POS    = 5;

    // Mask bits 1 to CHOICE_COUNT take part in the choice.
    localparam logic [WORD_W-1:0] USED_MASK =
        WORD_W'((33'd1 << (CHOICE_COUNT + 1)) - 33'd1) & ~WORD_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_WEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_MASK  = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0] request_word;
        logic [WORD_W-1:0] source_pointer;
        logic [TYPE_W-1:0] obj_type;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]   rewritten_word;
        logic                rerolled;
        logic [CHOICE_W-1:0] chosen_value;
        logic [WORD_W-1:0]   table_address;
        logic [WORD_W-1:0]   reroll_count;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_HASH1,
        ST_HASH2,
        ST_HASH3,
        ST_XS13,
        ST_XS17,
        ST_XS5,
        ST_MOD,
        ST_SCAN,
        ST_FINISH
    } st_t;

endpackage

// ----- rtl/core/random_masked_choice_reroller.sv -----
// Top level of the random masked choice reroller: sequencer, shared multiplier,
// remainder unit, choice scan and result register. Depends on rmcr_pkg.

// One request beat yields one result beat. A pass-through request (block
// disabled or request bit 5 set) goes from accept straight to the result load.
// A reroll steps through accept, seeding of the generator when its state is
// zero (ST_SEED to ST_HASH3), an xorshift draw (ST_XS13 to ST_XS5) and a modulo
// for the weight roll and again for the choice (the shared remainder stage
// retires two dividend bits a cycle), a scan of the mask for the chosen bit
// (four bits a cycle) and the result load. A weight of 100 or more ends the
// reroll after the first draw and a roll of none after the first modulo.
// The block takes one request at a time; req_stall stays high from accept until
// the result is loaded into the output register, which frees the request side
// while a finished beat still waits on rsp_stall. Configuration writes are
// always taken (cfg_ready is tied high) and must land while no request is in
// flight. The generator seeds itself from seed_low and seed_high on the first
// draw after reset only; later seed writes have no effect until the next reset.
module random_masked_choice_reroller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  rmcr_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output rmcr_pkg::rsp_t                    rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rmcr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rmcr_pkg::WORD_W-1:0]       cfg_data
);
    import rmcr_pkg::*;

    // Configuration registers
    logic                random_enable_reg;
    logic [WORD_W-1:0]   seed_low_reg;
    logic [WORD_W-1:0]   seed_high_reg;
    logic [WEIGHT_W-1:0] none_weight_reg;
    logic [WORD_W-1:0]   allowed_mask_reg;

    // Sequencer and architectural state
    st_t                 state_reg, state_next;
    logic [WORD_W-1:0]   gen_reg, gen_next;
    logic [WORD_W-1:0]   count_reg, count_next;
    logic                second_reg, second_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // Datapath registers
    logic [WORD_W-1:0]   work_reg, work_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [CHOICE_W-1:0] k_reg, k_next;
    logic [CHOICE_W-1:0] choice_reg, choice_next;
    req_t                item_reg, item_next;
    rsp_t                rsp_reg, rsp_next;

    // Shared multiplier, low word only
    logic [WORD_W-1:0]   mul_a, mul_b, prod;

    // Combinational helpers
    logic [WORD_W-1:0]   xs_val;
    logic [DIV_W:0]      rem_v;
    logic [DIV_W-1:0]    rem_step;
    logic [DIV_W-1:0]    pop_v;
    logic [CHOICE_W-1:0] k_v;
    logic                found_v;
    logic [CHOICE_W-1:0] pos_v;
    logic                did;
    logic                in_window;
    logic [WORD_W-1:0]   addr_v;

    assign prod      = mul_a * mul_b;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // Remainder stage: restoring division, MOD_BITS dividend bits per cycle.
    always_comb
    begin
        rem_v = {1'b0, rem_reg};
        for (int b = 0; b < MOD_BITS; b++)
        begin
            rem_v = {rem_v[DIV_W-1:0], work_reg[WORD_W-1-b]};
            if (rem_v >= {1'b0, div_reg})
            begin
                rem_v = rem_v - {1'b0, div_reg};
            end
        end
        rem_step = rem_v[DIV_W-1:0];
    end

    // Count the allowed choices.
    always_comb
    begin
        pop_v = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            pop_v = pop_v + DIV_W'(allowed_mask_reg[i] & USED_MASK[i]);
        end
    end

    // Scan SCAN_LANES mask bits for the k-th set bit; the mask shifts right in work_reg.
    always_comb
    begin
        k_v     = k_reg;
        found_v = 1'b0;
        pos_v   = '0;
        for (int j = 0; j < SCAN_LANES; j++)
        begin
            if (!found_v && work_reg[j])
            begin
                if (k_v == '0)
                begin
                    found_v = 1'b1;
                    pos_v   = {step_reg[SCAN_IDX_W-1:0], LANE_W'(j)};
                end
                else
                begin
                    k_v = k_v - CHOICE_W'(1);
                end
            end
        end
    end

    // Table address for pointers inside the work window: base + type * 24.
    assign did       = random_enable_reg && !item_reg.request_word[PASS_POS];
    assign in_window = (item_reg.source_pointer >= WINDOW_LOW)
                    && (item_reg.source_pointer < WINDOW_HIGH);
    assign addr_v    = TABLE_BASE + WORD_W'({item_reg.obj_type, 4'b0000})
                                  + WORD_W'({item_reg.obj_type, 3'b000});

    // Last xorshift step with the zero fix-up.
    always_comb
    begin
        xs_val = work_reg ^ (work_reg << 5);
        if (xs_val == '0)
        begin
            xs_val = NONZERO_FILL;
        end
    end

    // Next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        gen_next       = gen_reg;
        count_next     = count_reg;
        second_next    = second_reg;
        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        k_next         = k_reg;
        choice_next    = choice_reg;
        item_next      = item_reg;
        rsp_next       = rsp_reg;
        mul_a          = work_reg;
        mul_b          = MIX_MUL_A;

        // Drop the output beat once taken.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next   = req;
                    choice_next = '0;
                    second_next = 1'b0;
                    if (random_enable_reg && !req.request_word[PASS_POS])
                    begin
                        if (gen_reg == '0)
                        begin
                            state_next = ST_SEED;
                        end
                        else
                        begin
                            work_next  = gen_reg;
                            state_next = ST_XS13;
                        end
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SEED:
            begin
                mul_a      = seed_high_reg;
                mul_b      = GOLDEN;
                work_next  = seed_low_reg ^ prod ^ SEED_SALT;
                state_next = ST_HASH1;
            end
            ST_HASH1:
            begin
                mul_a      = work_reg ^ (work_reg >> 16);
                mul_b      = MIX_MUL_A;
                work_next  = prod;
                state_next = ST_HASH2;
            end
            ST_HASH2:
            begin
                mul_a      = work_reg ^ (work_reg >> 15);
                mul_b      = MIX_MUL_B;
                work_next  = prod;
                state_next = ST_HASH3;
            end
            ST_HASH3:
            begin
                work_next = work_reg ^ (work_reg >> 16);
                if (work_next == '0)
                begin
                    work_next = NONZERO_FILL;
                end
                state_next = ST_XS13;
            end
            ST_XS13:
            begin
                work_next  = work_reg ^ (work_reg << 13);
                state_next = ST_XS17;
            end
            ST_XS17:
            begin
                work_next  = work_reg ^ (work_reg >> 17);
                state_next = ST_XS5;
            end
            ST_XS5:
            begin
                gen_next  = xs_val;
                work_next = xs_val;
                rem_next  = '0;
                step_next = '0;
                if (!second_reg)
                begin
                    if (none_weight_reg >= WEIGHT_FULL)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (none_weight_reg == '0)
                    begin
                        second_next = 1'b1;
                        state_next  = ST_XS13;
                    end
                    else
                    begin
                        div_next   = PERCENT_DIV;
                        state_next = ST_MOD;
                    end
                end
                else if (pop_v == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_next   = pop_v;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                work_next = work_reg << MOD_BITS;
                rem_next  = rem_step;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MOD_STEPS - 1))
                begin
                    step_next = '0;
                    if (!second_reg)
                    begin
                        if ({1'b0, rem_step} < none_weight_reg)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            second_next = 1'b1;
                            work_next   = gen_reg;
                            state_next  = ST_XS13;
                        end
                    end
                    else
                    begin
                        k_next     = rem_step[CHOICE_W-1:0];
                        work_next  = allowed_mask_reg & USED_MASK;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (found_v)
                begin
                    choice_next = pos_v;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    k_next    = k_v;
                    work_next = work_reg >> SCAN_LANES;
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    if (did)
                    begin
                        count_next = count_reg + WORD_W'(1);
                    end
                    rsp_next.rewritten_word = did
                        ? {item_reg.request_word[WORD_W-1:CHOICE_W], choice_reg}
                        : item_reg.request_word;
                    rsp_next.rerolled      = did;
                    rsp_next.chosen_value  = choice_reg;
                    rsp_next.table_address = (did && in_window) ? addr_v : '0;
                    rsp_next.reroll_count  = count_next;
                    rsp_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg           <= '0;
            count_reg         <= '0;
            second_reg        <= 1'b0;
            step_reg          <= '0;
            rsp_valid_reg     <= 1'b0;
            random_enable_reg <= 1'b0;
            seed_low_reg      <= '0;
            seed_high_reg     <= '0;
            none_weight_reg   <= '0;
            allowed_mask_reg  <= '0;
        end
        else
        begin
            gen_reg       <= gen_next;
            count_reg     <= count_next;
            second_reg    <= second_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_RANDOM_ENABLE: random_enable_reg <= cfg_data[0];
                    REG_SEED_LOW:      seed_low_reg      <= cfg_data;
                    REG_SEED_HIGH:     seed_high_reg     <= cfg_data;
                    REG_NONE_WEIGHT:   none_weight_reg   <= cfg_data[WEIGHT_W-1:0];
                    REG_ALLOWED_MASK:  allowed_mask_reg  <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        k_reg      <= k_next;
        choice_reg <= choice_next;
        item_reg   <= item_next;
        rsp_reg    <= rsp_next;
    end

`ifndef ASSERT_OFF
    // Once seeded, the generator never returns to the unseeded state.
    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (gen_reg != '0) |=> (gen_reg != '0))
        else $error("generator state fell back to zero");

    // The running remainder stays below a nonzero divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |-> (rem_reg < div_reg))
        else $error("remainder out of range");

    // The scan finds the chosen bit before running off the mask.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (step_reg < STEP_W'(SCAN_STEPS)))
        else $error("choice scan overran the mask");

    // The reroll count moves only when a result is loaded.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_FINISH) |=> $stable(count_reg))
        else $error("reroll count changed outside result load");
`endif

endmodule
